// ----- rtl/core/salc_pkg.sv -----
// Shared types, constants and helpers for the set-associative LRU cache model.
package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_WIDTH_DEF   = 48;
    localparam int MAX_BLOCK_BITS   = 12;
    localparam int CNT_W            = 32;
    localparam int CFG_W            = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int MODE_W           = 2;
    localparam int OUTCOME_W        = 2;
    localparam int WAY_OUT_W        = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd2;

    // Access kinds
    localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd3;

    // Outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_COLD  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_FETCH = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [ADDR_WIDTH_DEF-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [WAY_OUT_W-1:0] way_used;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
        logic [CNT_W-1:0]     eviction_total;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR
    } t_back_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// ----- rtl/core/salc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/salc_front.sv -----
// Front end: accepts items, splits the address and queues set/tag work.
module salc_front #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  salc_pkg::t_in_item       i_item,
    input  logic [2:0]               i_set_bits,
    input  logic [3:0]               i_block_bits,
    output logic                     o_q_valid,
    input  logic                     i_q_take,
    output logic [salc_pkg::MODE_W-1:0] o_q_mode,
    output logic [SET_W-1:0]         o_q_set,
    output logic [salc_pkg::ADDR_WIDTH_DEF-1:0] o_q_tag
);
    import salc_pkg::*;

    localparam int ADDR_WIDTH = ADDR_WIDTH_DEF;
    localparam int QW = MODE_W + SET_W + ADDR_WIDTH;

    logic [3:0]            sb;
    logic [3:0]            bb;
    logic [4:0]            sh;
    logic [ADDR_WIDTH-1:0] addr;
    logic [ADDR_WIDTH-1:0] shifted;
    logic [SET_W-1:0]      set_mask;
    logic [QW-1:0]         r_q0, r_q1;
    logic [QW-1:0]         n_entry;
    logic [1:0]            r_cnt;
    logic                  push_ok;

    // Clamp the split and cut the address
    always_comb begin
        sb = ({1'b0, i_set_bits} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, i_set_bits};
        bb = (i_block_bits > 4'(MAX_BLOCK_BITS)) ? 4'(MAX_BLOCK_BITS) : i_block_bits;
        sh = 5'(sb) + 5'(bb);
        addr = i_item.address[ADDR_WIDTH-1:0];
        shifted = addr >> bb;
        set_mask = SET_W'((({SET_W+1{1'b0}} | 1) << sb) - 1);
        n_entry = {i_item.mode, shifted[SET_W-1:0] & set_mask,
                   (32'(sh) >= ADDR_WIDTH) ? {ADDR_WIDTH{1'b0}} : (addr >> sh)};
    end

    assign o_full   = (r_cnt == 2'd2);
    assign push_ok  = i_push && !o_full;
    assign o_q_valid = (r_cnt != 2'd0);
    assign {o_q_mode, o_q_set, o_q_tag} = r_q0;

    // Two-entry queue towards the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(push_ok) - 2'(i_q_take && o_q_valid);
        end
        if (i_q_take && o_q_valid) begin
            if (r_cnt == 2'd2) r_q0 <= r_q1;
            else if (push_ok) r_q0 <= n_entry;
            if (push_ok) r_q1 <= n_entry;
        end else if (push_ok) begin
            if (r_cnt == 2'd0) r_q0 <= n_entry;
            else r_q1 <= n_entry;
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count out of range");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_q_take) |=> o_full) else $error("full dropped without take");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_q_valid && !i_push) |=> !o_q_valid) else $error("item invented");
endmodule

// ----- rtl/core/salc_back.sv -----
// Back end: reads a set, resolves hit/fill/evict, writes back for all but fetches, keeps totals.
module salc_back #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [3:0]                  i_ways,
    input  logic                        i_q_valid,
    output logic                        o_q_take,
    input  logic [salc_pkg::MODE_W-1:0] i_q_mode,
    input  logic [SET_W-1:0]            i_q_set,
    input  logic [salc_pkg::ADDR_WIDTH_DEF-1:0] i_q_tag,
    output logic                        o_empty,
    input  logic                        i_pop,
    output salc_pkg::t_out_item         o_item
);
    import salc_pkg::*;

    localparam int MAX_WAYS = MAX_WAYS_DEF;
    localparam int ADDR_WIDTH = ADDR_WIDTH_DEF;
    localparam int NSETS = 1 << MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int RANK_TOP = MAX_WAYS - 1;
    localparam int WAYS_W = $clog2(MAX_WAYS + 1);
    localparam int ROW_W = MAX_WAYS * (1 + ADDR_WIDTH + RANK_W);
    localparam int SADDR_W = (NSETS > 1) ? $clog2(NSETS) : 1;

    t_back_state r_state, n_state;
    logic [SADDR_W-1:0]     r_clr, n_clr;
    logic [MODE_W-1:0]      r_mode;
    logic [SET_W-1:0]       r_set;
    logic [ADDR_WIDTH-1:0]  r_tag;
    logic [CNT_W-1:0]       r_hit, r_miss, r_evict, n_hit, n_miss, n_evict;
    logic                   r_out_v;
    t_out_item              r_out, n_out;
    logic                   we;
    logic [SADDR_W-1:0]     waddr, raddr;
    logic [ROW_W-1:0]       wrow, rrow;
    logic [MAX_WAYS-1:0]    v_rd, v_wr;
    logic [ADDR_WIDTH-1:0]  t_rd [MAX_WAYS];
    logic [ADDR_WIDTH-1:0]  t_wr [MAX_WAYS];
    logic [RANK_W-1:0]      k_rd [MAX_WAYS];
    logic [RANK_W-1:0]      k_wr [MAX_WAYS];
    logic [WAYS_W-1:0]      nw;
    logic                   hit, cold;
    logic [WAY_W-1:0]       hw, cw, ew, way;
    logic [RANK_W-1:0]      best;
    logic [RANK_W:0]        old_rank;
    logic                   slot_free;

    // Set memory: one row holds valid, tag and rank of every way
    salc_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wrow),
        .i_raddr(raddr), .o_rdata(rrow));

    assign raddr = SADDR_W'(i_q_set);
    assign slot_free = !r_out_v || i_pop;

    // Unpack and resolve the way
    always_comb begin
        nw = (i_ways == 4'd0) ? WAYS_W'(1) :
             (32'(i_ways) > MAX_WAYS) ? WAYS_W'(MAX_WAYS) : WAYS_W'(i_ways);
        hit = 1'b0; cold = 1'b0; hw = '0; cw = '0; ew = '0; best = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            v_rd[w] = rrow[w*(1+ADDR_WIDTH+RANK_W) + ADDR_WIDTH + RANK_W];
            t_rd[w] = rrow[w*(1+ADDR_WIDTH+RANK_W) + RANK_W +: ADDR_WIDTH];
            k_rd[w] = rrow[w*(1+ADDR_WIDTH+RANK_W) +: RANK_W];
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (w < 32'(nw)) begin
                if (v_rd[w] && t_rd[w] == r_tag) begin hit = 1'b1; hw = WAY_W'(w); end
                if (!v_rd[w]) begin cold = 1'b1; cw = WAY_W'(w); end
                if (k_rd[w] >= best) begin best = k_rd[w]; ew = WAY_W'(w); end
            end
        end
        way = hit ? hw : (cold ? cw : ew);
        old_rank = (!hit && cold) ? (RANK_W+1)'(MAX_WAYS) : {1'b0, k_rd[way]};
        for (int w = 0; w < MAX_WAYS; w++) begin
            v_wr[w] = v_rd[w]; t_wr[w] = t_rd[w]; k_wr[w] = k_rd[w];
            if (w < 32'(nw) && WAY_W'(w) != way && v_rd[w] &&
                {1'b0, k_rd[w]} < old_rank && 32'(k_rd[w]) < RANK_TOP)
                k_wr[w] = k_rd[w] + 1'b1;
            if (WAY_W'(w) == way) begin
                v_wr[w] = 1'b1; t_wr[w] = r_tag; k_wr[w] = '0;
            end
        end
    end

    // Sequencer: clear, read, update
    always_comb begin
        n_state = r_state; n_clr = r_clr; we = 1'b0; waddr = SADDR_W'(r_set);
        wrow = '0; o_q_take = 1'b0;
        n_hit = r_hit; n_miss = r_miss; n_evict = r_evict; n_out = r_out;
        for (int w = 0; w < MAX_WAYS; w++)
            wrow[w*(1+ADDR_WIDTH+RANK_W) +: 1+ADDR_WIDTH+RANK_W] = {v_wr[w], t_wr[w], k_wr[w]};
        case (r_state)
            ST_CLEAR: begin
                we = 1'b1; waddr = r_clr; wrow = '0;
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == NSETS - 1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_q_valid && slot_free) begin
                    o_q_take = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_out.way_used = '0;
                if (r_mode == MODE_FETCH) begin
                    n_out.outcome = OUT_FETCH;
                end else begin
                    we = 1'b1;
                    n_out.way_used = WAY_OUT_W'(way);
                    if (hit) begin
                        n_out.outcome = OUT_HIT; n_hit = sat_inc(n_hit);
                    end else begin
                        n_miss = sat_inc(r_miss);
                        if (cold) n_out.outcome = OUT_COLD;
                        else begin n_out.outcome = OUT_EVICT; n_evict = sat_inc(r_evict); end
                    end
                    if (r_mode == MODE_MODIFY) n_hit = sat_inc(n_hit);
                end
                n_out.hit_total = n_hit; n_out.miss_total = n_miss;
                n_out.eviction_total = n_evict;
                n_state = ST_UPDATE;
            end
            ST_UPDATE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_empty = !r_out_v;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR; r_clr <= '0; r_out_v <= 1'b0;
            r_hit <= '0; r_miss <= '0; r_evict <= '0;
        end else begin
            r_state <= n_state; r_clr <= n_clr;
            r_hit <= n_hit; r_miss <= n_miss; r_evict <= n_evict;
            if (r_state == ST_READ) r_out_v <= 1'b1;
            else if (i_pop) r_out_v <= 1'b0;
        end
        if (o_q_take) begin r_mode <= i_q_mode; r_set <= i_q_set; r_tag <= i_q_tag; end
        r_out <= n_out;
    end

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_take |=> r_state == ST_READ) else $error("take without read");
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (o_empty || i_pop)) else $error("result overwritten");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss >= $past(r_miss)) else $error("miss total went backwards");
endmodule

// ----- rtl/core/set_assoc_lru_cache_model.sv -----
// Set-associative LRU cache model: top level with config registers.
// An item passes the back end in steps (read the set row through the registered read of
// the set memory, resolve and write it back, a turnaround); the front queue holds two
// items. After reset a clearing pass writes all 2**MAX_SET_BITS rows of the set memory
// to zero before the first item is processed. Totals saturate at 2**32-1.
module set_assoc_lru_cache_model #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  salc_pkg::t_in_item             i_item,
    output logic                           empty,
    input  logic                           pop,
    output salc_pkg::t_out_item            o_item,
    input  logic                           i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [salc_pkg::CFG_W-1:0]     i_cfg_data
);
    import salc_pkg::*;

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    logic [2:0] r_set_bits;
    logic [3:0] r_ways, r_block_bits;
    logic                      q_valid, q_take;
    logic [MODE_W-1:0]         q_mode;
    logic [SET_W-1:0]          q_set;
    logic [ADDR_WIDTH_DEF-1:0] q_tag;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= 3'd4; r_ways <= 4'd1; r_block_bits <= 4'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                REG_WAYS:       r_ways       <= i_cfg_data;
                REG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    salc_front #(.MAX_SET_BITS(MAX_SET_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full), .i_item(i_item),
        .i_set_bits(r_set_bits), .i_block_bits(r_block_bits),
        .o_q_valid(q_valid), .i_q_take(q_take), .o_q_mode(q_mode),
        .o_q_set(q_set), .o_q_tag(q_tag));

    salc_back #(.MAX_SET_BITS(MAX_SET_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ways(r_ways),
        .i_q_valid(q_valid), .o_q_take(q_take), .i_q_mode(q_mode),
        .i_q_set(q_set), .i_q_tag(q_tag),
        .o_empty(empty), .i_pop(pop), .o_item(o_item));
endmodule
